>>> rtl/desp_pkg.sv
// ----------------------------------------------------------------------------
// desp_pkg
// Shared types and constants for the DER signature parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package desp_pkg;

  localparam logic [7:0] SEQ_TAG  = 8'h30;
  localparam logic [7:0] INT_TAG  = 8'h02;
  localparam int unsigned LONG_FORM_BIT = 7;  // 0x80 marks a long-form length

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NOT_IMPL  = 2'd2
  } desp_status_t;

  typedef enum logic [1:0] {
    PART_NONE = 2'd0,
    PART_R    = 2'd1,
    PART_S    = 2'd2
  } desp_part_t;

  // One classified input byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_seq_tag;
    logic       is_int_tag;
    logic       long_form;
  } desp_item_t;

  localparam int unsigned ITEM_W = $bits(desp_item_t);

endpackage

>>> rtl/der_ecdsa_signature_parser_core.sv
// ----------------------------------------------------------------------------
// der_ecdsa_signature_parser_core
// Short-form DER decoder for a SEQUENCE of two INTEGERs (r, s).
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata der_byte, tlast last
//  out_    | out | out_tvalid / out_tready| tdata content/index/status/lens,
//          |     |                        | tuser part, tlast done_res
//
//  One byte per cycle sustained while out_tready is high; an accepted byte
//  passes through the queue register, then the parser output register.
//  Every accepted byte produces exactly one result transfer.
//  rst_n is synchronous, active low; it empties the queue and returns the
//  parser to the sequence-tag phase. No clearing pass is needed.
//  Output stalls fill the queue; in_tready drops only when it is full.
//  Parser state returns to reset values after each final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module der_ecdsa_signature_parser_core import desp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] der_byte
  input  logic        in_tlast,    // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] content_byte, [14:8] byte_index,
                                   // [16:15] status, [23:17] r_length,
                                   // [30:24] s_length, [31] zero
  output logic [1:0]  out_tuser,   // [1:0] part
  output logic        out_tlast    // done_res
);

  desp_item_t q_in_item;
  desp_item_t q_head_item;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;

  // Front: classify each byte and transfer it into the queue.
  desp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  // Queue: decouple input acceptance from output stalls.
  desp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  // Back: run the parser and hold each result until transferred.
  desp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/desp_front.sv
// ----------------------------------------------------------------------------
// desp_front
// Input side: accept bytes and tag them with their tag and length-form flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module desp_front import desp_pkg::*; (
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] der_byte
  input  logic       in_tlast,    // last
  input  logic       q_full,
  output logic       q_push,
  output desp_item_t q_item
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.data       = in_tdata;
    q_item.last       = in_tlast;
    q_item.is_seq_tag = (in_tdata == SEQ_TAG);
    q_item.is_int_tag = (in_tdata == INT_TAG);
    q_item.long_form  = in_tdata[LONG_FORM_BIT];
  end

endmodule

>>> rtl/desp_queue.sv
// ----------------------------------------------------------------------------
// desp_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module desp_queue import desp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  desp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output desp_item_t head_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desp_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> rd_ptr_r != $past(rd_ptr_r) || DEPTH == 1)
    else $error("pop did not advance read pointer");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> count_r == FULL_CNT)
    else $error("count changed while full without a pop");

endmodule

>>> rtl/desp_back.sv
// ----------------------------------------------------------------------------
// desp_back
// Parser state machine and output register; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module desp_back import desp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  desp_item_t  head_item,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  typedef enum logic [3:0] {
    PH_SEQ_TAG = 4'd0,
    PH_SEQ_LEN = 4'd1,
    PH_R_TAG   = 4'd2,
    PH_R_LEN   = 4'd3,
    PH_R_BODY  = 4'd4,
    PH_S_TAG   = 4'd5,
    PH_S_LEN   = 4'd6,
    PH_S_BODY  = 4'd7,
    PH_S_DONE  = 4'd8,
    PH_SKIP    = 4'd9
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [6:0]   seq_left_r, seq_left_nxt;
  logic [6:0]   int_left_r, int_left_nxt;
  logic [6:0]   r_size_r, r_size_nxt;
  logic [6:0]   s_size_r, s_size_nxt;
  desp_status_t hdr_err_r, hdr_err_nxt;
  desp_status_t body_err_r, body_err_nxt;
  logic         overrun_r, overrun_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   content_r, content_nxt;
  desp_part_t   part_r, part_nxt;
  logic [6:0]   index_r, index_nxt;
  logic         done_r, done_nxt;
  desp_status_t status_r, status_nxt;
  logic [6:0]   r_len_r, r_len_nxt;
  logic [6:0]   s_len_r, s_len_nxt;

  logic [7:0]   b;

  assign pop = head_valid && (!out_valid_r || out_tready);
  assign b   = head_item.data;

  always_comb begin
    phase_nxt     = phase_r;
    seq_left_nxt  = seq_left_r;
    int_left_nxt  = int_left_r;
    r_size_nxt    = r_size_r;
    s_size_nxt    = s_size_r;
    hdr_err_nxt   = hdr_err_r;
    body_err_nxt  = body_err_r;
    overrun_nxt   = overrun_r;
    out_valid_nxt = out_valid_r && !out_tready;
    content_nxt   = content_r;
    part_nxt      = part_r;
    index_nxt     = index_r;
    done_nxt      = done_r;
    status_nxt    = status_r;
    r_len_nxt     = r_len_r;
    s_len_nxt     = s_len_r;

    if (pop) begin
      out_valid_nxt = 1'b1;
      content_nxt   = '0;
      part_nxt      = PART_NONE;
      index_nxt     = '0;
      done_nxt      = head_item.last;
      status_nxt    = ST_OK;
      r_len_nxt     = '0;
      s_len_nxt     = '0;

      if (phase_r == PH_SEQ_TAG) begin
        if (head_item.is_seq_tag) begin
          phase_nxt = PH_SEQ_LEN;
        end else begin
          hdr_err_nxt = ST_MALFORMED;
          phase_nxt   = PH_SKIP;
        end
      end else if (phase_r == PH_SEQ_LEN) begin
        if (head_item.long_form) begin
          hdr_err_nxt = ST_NOT_IMPL;
          phase_nxt   = PH_SKIP;
        end else begin
          seq_left_nxt = b[6:0];
          phase_nxt    = PH_R_TAG;
        end
      end else if (seq_left_r == '0) begin
        overrun_nxt = 1'b1;
      end else begin
        seq_left_nxt = seq_left_r - 1'b1;
        unique case (phase_r)
          PH_R_TAG, PH_S_TAG: begin
            if (head_item.is_int_tag) begin
              phase_nxt = (phase_r == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
            end else begin
              body_err_nxt = ST_MALFORMED;
              phase_nxt    = PH_SKIP;
            end
          end
          PH_R_LEN, PH_S_LEN: begin
            if (head_item.long_form) begin
              body_err_nxt = ST_NOT_IMPL;
              phase_nxt    = PH_SKIP;
            end else if (b[6:0] > seq_left_nxt) begin
              body_err_nxt = ST_MALFORMED;
              phase_nxt    = PH_SKIP;
            end else begin
              int_left_nxt = b[6:0];
              if (phase_r == PH_R_LEN) begin
                r_size_nxt = b[6:0];
                phase_nxt  = (b[6:0] != '0) ? PH_R_BODY : PH_S_TAG;
              end else begin
                s_size_nxt = b[6:0];
                phase_nxt  = (b[6:0] != '0) ? PH_S_BODY : PH_S_DONE;
              end
            end
          end
          PH_R_BODY, PH_S_BODY: begin
            part_nxt     = (phase_r == PH_R_BODY) ? PART_R : PART_S;
            index_nxt    = ((phase_r == PH_R_BODY) ? r_size_r : s_size_r) - int_left_r;
            content_nxt  = b;
            int_left_nxt = int_left_r - 1'b1;
            if (int_left_nxt == '0) begin
              phase_nxt = (phase_r == PH_R_BODY) ? PH_S_TAG : PH_S_DONE;
            end
          end
          PH_S_DONE: begin
            body_err_nxt = ST_MALFORMED;
            phase_nxt    = PH_SKIP;
          end
          default: begin
          end
        endcase
      end

      if (head_item.last) begin
        // Final verdict in priority order, then return to reset values.
        if (hdr_err_nxt != ST_OK) begin
          status_nxt = hdr_err_nxt;
        end else if (phase_nxt == PH_SEQ_TAG || phase_nxt == PH_SEQ_LEN) begin
          status_nxt = ST_MALFORMED;
        end else if (overrun_nxt || seq_left_nxt != '0) begin
          status_nxt = ST_MALFORMED;
        end else if (body_err_nxt != ST_OK) begin
          status_nxt = body_err_nxt;
        end else if (phase_nxt != PH_S_DONE) begin
          status_nxt = ST_MALFORMED;
        end else begin
          status_nxt = ST_OK;
          r_len_nxt  = r_size_nxt;
          s_len_nxt  = s_size_nxt;
        end
        phase_nxt    = PH_SEQ_TAG;
        seq_left_nxt = '0;
        int_left_nxt = '0;
        r_size_nxt   = '0;
        s_size_nxt   = '0;
        hdr_err_nxt  = ST_OK;
        body_err_nxt = ST_OK;
        overrun_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEQ_TAG;
      seq_left_r  <= '0;
      int_left_r  <= '0;
      r_size_r    <= '0;
      s_size_r    <= '0;
      hdr_err_r   <= ST_OK;
      body_err_r  <= ST_OK;
      overrun_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_left_r  <= seq_left_nxt;
      int_left_r  <= int_left_nxt;
      r_size_r    <= r_size_nxt;
      s_size_r    <= s_size_nxt;
      hdr_err_r   <= hdr_err_nxt;
      body_err_r  <= body_err_nxt;
      overrun_r   <= overrun_nxt;
      out_valid_r <= out_valid_nxt;
    end
    content_r <= content_nxt;
    part_r    <= part_nxt;
    index_r   <= index_nxt;
    done_r    <= done_nxt;
    status_r  <= status_nxt;
    r_len_r   <= r_len_nxt;
    s_len_r   <= s_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tuser  = part_r;
  assign out_tdata  = {1'b0, s_len_r, r_len_r, status_r, index_r, content_r};

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK)
    else $error("status reported before the final byte");

  a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> r_len_r == '0 && s_len_r == '0)
    else $error("lengths reported with an error status");

  a_skip_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> hdr_err_r != ST_OK || body_err_r != ST_OK)
    else $error("skip phase without a latched error");

  a_content_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    pop && part_nxt != PART_NONE |-> phase_r == PH_R_BODY || phase_r == PH_S_BODY)
    else $error("content byte outside an integer body");

endmodule
